/* design/gott_pkg.sv */
// Package: constants and types for the gated object track table.
package gott_pkg;
  localparam int TABLE_SLOTS_DEF = 16;
  localparam int GATE_RESET = 35;
  localparam int EXPIRY_RESET = 500;
  localparam logic CFG_GATE = 1'b0;
  localparam logic CFG_EXPIRY = 1'b1;
  localparam logic KIND_DET = 1'b0;
  localparam logic KIND_EOF = 1'b1;
  typedef struct packed {
    logic signed [10:0] x;
    logic signed [10:0] y;
    logic [13:0] d;
  } det_t;
endpackage

/* design/gated_object_track_table_core.sv */
// Top level: per-frame gated track table with a sequenced association pass.
// A detection request is buffered while idle if a pending entry is free. An
// end-of-frame request runs a sequencer that visits each live slot and
// compares it to the buffered detections until the first unused one inside
// the gate, one compare per cycle through a single gate comparator, then
// places unmatched detections in free slots, finds the nearest track and
// emits the results. Results come out one per cycle for slots
// 0..TABLE_SLOTS-1 on out_valid; the receiver cannot stall.
// busy is high from acceptance of end of frame and drops as the last result
// appears on out_valid.
module gated_object_track_table_core
  import gott_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  logic in_kind,
  input  logic signed [10:0] in_det_x,
  input  logic signed [10:0] in_det_y,
  input  logic [13:0] in_det_distance,
  input  logic [11:0] in_frame_ms,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic cfg_index,
  input  logic [15:0] cfg_data,
  output logic out_valid,
  output logic [3:0] out_slot,
  output logic out_slot_valid,
  output logic [7:0] out_track_id,
  output logic signed [10:0] out_pos_x,
  output logic signed [10:0] out_pos_y,
  output logic [13:0] out_distance,
  output logic out_predicted,
  output logic [3:0] out_nearest_slot,
  output logic out_last
);
  localparam int TABLE_SLOTS = TABLE_SLOTS_DEF;
  localparam int SW = $clog2(TABLE_SLOTS);
  localparam int CW = $clog2(TABLE_SLOTS + 1);

  localparam logic [2:0] ST_IDLE = 3'd0, ST_TRK = 3'd1, ST_CMP = 3'd2,
                         ST_NEW = 3'd3, ST_NEAR = 3'd4, ST_OUT = 3'd5;

  logic [2:0] st_r;
  logic [7:0] gate_r;
  logic [15:0] expiry_r;
  logic [11:0] fms_r;
  logic [CW-1:0] pcnt_r;
  logic [7:0] idc_r;
  logic [SW-1:0] s_r;
  logic [CW-1:0] j_r;
  logic [TABLE_SLOTS-1:0] tv_r, tp_r, pm_r;
  logic [7:0] tid_r [TABLE_SLOTS];
  det_t tdet_r [TABLE_SLOTS];
  logic [15:0] lost_r [TABLE_SLOTS];
  det_t pend_r [TABLE_SLOTS];
  logic [SW-1:0] near_r;
  logic [13:0] best_r;
  logic best_ok_r;

  logic [SW-1:0] jidx;
  det_t tc, pc;
  logic signed [12:0] g13, dx, dy;
  logic hit;
  logic [16:0] lsum;

  assign jidx = j_r[SW-1:0];
  assign tc = tdet_r[s_r];
  assign pc = pend_r[jidx];
  assign g13 = $signed({5'd0, gate_r});
  assign dx = 13'(signed'(pc.x)) - 13'(signed'(tc.x));
  assign dy = 13'(signed'(pc.y)) - 13'(signed'(tc.y));
  assign hit = !pm_r[jidx] && dx >= -g13 && dx < g13 && dy >= -g13 && dy < g13;
  assign lsum = {1'b0, lost_r[s_r]} + {5'd0, fms_r};

  assign busy = (st_r != ST_IDLE);
  assign cfg_ready = (st_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      gate_r <= 8'(GATE_RESET);
      expiry_r <= 16'(EXPIRY_RESET);
      pcnt_r <= '0;
      idc_r <= '0;
      tv_r <= '0;
      tp_r <= '0;
      pm_r <= '0;
      out_valid <= 1'b0;
      s_r <= '0;
      j_r <= '0;
    end else begin
      out_valid <= (st_r == ST_OUT);
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_GATE) gate_r <= cfg_data[7:0];
        else expiry_r <= cfg_data;
      end
      case (st_r)
        ST_IDLE: begin
          if (start) begin
            if (in_kind == KIND_DET) begin
              if (pcnt_r < CW'(TABLE_SLOTS)) begin
                pend_r[pcnt_r[SW-1:0]] <= '{in_det_x, in_det_y, in_det_distance};
                pm_r[pcnt_r[SW-1:0]] <= 1'b0;
                pcnt_r <= pcnt_r + CW'(1);
              end
            end else begin
              fms_r <= in_frame_ms;
              s_r <= '0;
              st_r <= ST_TRK;
            end
          end
        end
        ST_TRK: begin
          j_r <= '0;
          if (!tv_r[s_r]) begin
            if (s_r == SW'(TABLE_SLOTS - 1)) begin st_r <= ST_NEW; s_r <= '0; end
            else s_r <= s_r + SW'(1);
          end else if (tp_r[s_r] && lost_r[s_r] > expiry_r) begin
            tv_r[s_r] <= 1'b0;
            if (s_r == SW'(TABLE_SLOTS - 1)) begin st_r <= ST_NEW; s_r <= '0; end
            else s_r <= s_r + SW'(1);
          end else st_r <= ST_CMP;
        end
        ST_CMP: begin
          if (j_r < pcnt_r && hit) begin
            tdet_r[s_r] <= pc;
            lost_r[s_r] <= '0;
            tp_r[s_r] <= 1'b0;
            pm_r[jidx] <= 1'b1;
          end else if (j_r >= pcnt_r) begin
            tp_r[s_r] <= 1'b1;
            lost_r[s_r] <= lsum[16] ? 16'hFFFF : lsum[15:0];
          end
          if (j_r < pcnt_r && !hit) j_r <= j_r + CW'(1);
          else begin
            if (s_r == SW'(TABLE_SLOTS - 1)) begin st_r <= ST_NEW; s_r <= '0; end
            else begin s_r <= s_r + SW'(1); st_r <= ST_TRK; end
            j_r <= '0;
          end
        end
        ST_NEW: begin
          // s_r: free-slot scan, j_r: pending scan
          if (j_r >= pcnt_r) begin
            st_r <= ST_NEAR; s_r <= '0; best_ok_r <= 1'b0;
            near_r <= SW'(TABLE_SLOTS - 1);
          end else if (pm_r[jidx]) j_r <= j_r + CW'(1);
          else if (tv_r[s_r]) begin
            if (s_r == SW'(TABLE_SLOTS - 1)) begin
              st_r <= ST_NEAR; s_r <= '0; best_ok_r <= 1'b0;
              near_r <= SW'(TABLE_SLOTS - 1);
            end else s_r <= s_r + SW'(1);
          end else begin
            idc_r <= idc_r + 8'd1;
            tv_r[s_r] <= 1'b1;
            tp_r[s_r] <= 1'b0;
            tid_r[s_r] <= idc_r + 8'd1;
            tdet_r[s_r] <= pc;
            lost_r[s_r] <= '0;
            j_r <= j_r + CW'(1);
          end
        end
        ST_NEAR: begin
          if (tv_r[s_r] && (!best_ok_r || tc.d < best_r)) begin
            best_r <= tc.d; best_ok_r <= 1'b1; near_r <= s_r;
          end
          if (s_r == SW'(TABLE_SLOTS - 1)) begin st_r <= ST_OUT; s_r <= '0; end
          else s_r <= s_r + SW'(1);
        end
        ST_OUT: begin
          out_slot <= 4'(s_r);
          out_slot_valid <= tv_r[s_r];
          out_track_id <= tv_r[s_r] ? tid_r[s_r] : '0;
          out_pos_x <= tv_r[s_r] ? tc.x : '0;
          out_pos_y <= tv_r[s_r] ? tc.y : '0;
          out_distance <= tv_r[s_r] ? tc.d : '0;
          out_predicted <= tv_r[s_r] && tp_r[s_r];
          out_last <= (s_r == SW'(TABLE_SLOTS - 1));
          out_nearest_slot <= (s_r == SW'(TABLE_SLOTS - 1)) ? 4'(near_r) : '0;
          if (s_r == SW'(TABLE_SLOTS - 1)) begin
            st_r <= ST_IDLE; pcnt_r <= '0; pm_r <= '0;
          end else s_r <= s_r + SW'(1);
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready |-> !busy) else $error("cfg taken while busy");
  a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_OUT) |=> out_valid) else $error("missing result");
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> !busy) else $error("busy after last");
  a_pcnt: assert property (@(posedge clk) disable iff (!rst_n)
    pcnt_r <= CW'(TABLE_SLOTS)) else $error("pending overflow");
endmodule

/* bench/tb_gated_object_track_table_core.sv */
// Testbench for the gated object track table: directed table, then random frames.
module tb_gated_object_track_table_core;
  import gott_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = 16;
  localparam int TIMEOUT_CYCLES = 600000;

  typedef struct {
    logic [3:0] slot;
    logic slot_valid;
    logic [7:0] track_id;
    logic signed [10:0] pos_x;
    logic signed [10:0] pos_y;
    logic [13:0] distance;
    logic predicted;
    logic [3:0] nearest_slot;
    logic last;
  } slot_report_t;

  typedef struct {
    logic kind;
    int x;
    int y;
    int d;
    int ms;
    int near;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_kind = KIND_DET;
  logic signed [10:0] in_det_x = '0;
  logic signed [10:0] in_det_y = '0;
  logic [13:0] in_det_distance = '0;
  logic [11:0] in_frame_ms = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = CFG_GATE;
  logic [15:0] cfg_data = '0;
  logic out_valid;
  logic [3:0] out_slot;
  logic out_slot_valid;
  logic [7:0] out_track_id;
  logic signed [10:0] out_pos_x;
  logic signed [10:0] out_pos_y;
  logic [13:0] out_distance;
  logic out_predicted;
  logic [3:0] out_nearest_slot;
  logic out_last;

  gated_object_track_table_core DUT (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  // track table mirror
  int gate_w = GATE_RESET;
  int expiry_w = EXPIRY_RESET;
  bit tv[SLOTS];
  bit tp[SLOTS];
  logic [7:0] tid[SLOTS];
  int tx[SLOTS];
  int ty[SLOTS];
  int td[SLOTS];
  int tlost[SLOTS];
  int px[$];
  int py[$];
  int pd[$];
  logic [7:0] id_ctr = '0;

  slot_report_t slot_reports[$];
  int typed_nearest[$];
  int errors = 0;
  int cycles = 0;
  int items = 0;

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic bit gate_hit(input int t, input int v);
    return v >= t - gate_w && v < t + gate_w;
  endfunction

  function automatic void run_association(input int ms);
    bit used[SLOTS];
    bit hit;
    int fr;
    int best;
    int near;
    slot_report_t r;
    foreach (used[j]) used[j] = 0;
    for (int s = 0; s < SLOTS; s++) begin
      if (!tv[s]) continue;
      if (tp[s] && tlost[s] > expiry_w) begin
        tv[s] = 0;
        continue;
      end
      hit = 0;
      for (int j = 0; j < px.size(); j++) begin
        if (!used[j] && gate_hit(tx[s], px[j]) && gate_hit(ty[s], py[j])) begin
          tx[s] = px[j];
          ty[s] = py[j];
          td[s] = pd[j];
          tlost[s] = 0;
          tp[s] = 0;
          used[j] = 1;
          hit = 1;
          break;
        end
      end
      if (!hit) begin
        tp[s] = 1;
        tlost[s] = (tlost[s] + ms > 65535) ? 65535 : tlost[s] + ms;
      end
    end
    fr = 0;
    for (int j = 0; j < px.size(); j++) begin
      if (used[j]) continue;
      while (fr < SLOTS && tv[fr]) fr++;
      if (fr >= SLOTS) break;
      id_ctr = id_ctr + 8'd1;
      tv[fr] = 1;
      tp[fr] = 0;
      tid[fr] = id_ctr;
      tx[fr] = px[j];
      ty[fr] = py[j];
      td[fr] = pd[j];
      tlost[fr] = 0;
    end
    px.delete();
    py.delete();
    pd.delete();
    near = SLOTS - 1;
    best = 32'h7fffffff;
    for (int s = 0; s < SLOTS; s++) begin
      if (tv[s] && td[s] < best) begin
        best = td[s];
        near = s;
      end
    end
    for (int s = 0; s < SLOTS; s++) begin
      r.slot = s[3:0];
      r.slot_valid = tv[s];
      r.track_id = tv[s] ? tid[s] : 8'd0;
      r.pos_x = tv[s] ? 11'(tx[s]) : 11'sd0;
      r.pos_y = tv[s] ? 11'(ty[s]) : 11'sd0;
      r.distance = tv[s] ? 14'(td[s]) : 14'd0;
      r.predicted = tv[s] && tp[s];
      r.last = (s == SLOTS - 1);
      r.nearest_slot = r.last ? 4'(near) : 4'd0;
      slot_reports.insert(slot_reports.size(), r);
    end
  endfunction

  always @(posedge clk) begin
    slot_report_t w;
    if (rst_n) begin
      if (out_valid) begin
        if (slot_reports.size() == 0) begin
          report("unexpected result, slot", out_slot, -1);
        end else begin
          w = slot_reports.pop_front();
          if (out_slot !== w.slot) report("slot", out_slot, w.slot);
          if (out_slot_valid !== w.slot_valid) report("slot_valid", out_slot_valid, w.slot_valid);
          if (out_track_id !== w.track_id) report("track_id", out_track_id, w.track_id);
          if (out_pos_x !== w.pos_x) report("pos_x", out_pos_x, w.pos_x);
          if (out_pos_y !== w.pos_y) report("pos_y", out_pos_y, w.pos_y);
          if (out_distance !== w.distance) report("distance", out_distance, w.distance);
          if (out_predicted !== w.predicted) report("predicted", out_predicted, w.predicted);
          if (out_nearest_slot !== w.nearest_slot)
            report("nearest_slot", out_nearest_slot, w.nearest_slot);
          if (out_last !== w.last) report("last", out_last, w.last);
          if (w.last && typed_nearest.size() > 0) begin
            if (typed_nearest[0] >= 0 && out_nearest_slot !== 4'(typed_nearest[0]))
              report("table nearest_slot", out_nearest_slot, typed_nearest[0]);
            void'(typed_nearest.pop_front());
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_GATE) gate_w = cfg_data[7:0];
        else expiry_w = cfg_data;
      end
      if (start && !busy) begin
        if (in_kind == KIND_DET) begin
          if (px.size() < SLOTS) begin
            px.insert(px.size(), int'(in_det_x));
            py.insert(py.size(), int'(in_det_y));
            pd.insert(pd.size(), int'(in_det_distance));
          end
        end else begin
          run_association(in_frame_ms);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > TIMEOUT_CYCLES) begin
      $display("[gated_object_track_table_core] ERROR");
      $finish;
    end
  end

  task automatic send(input logic k, input int x, input int y, input int d, input int ms);
    start <= 1'b1;
    in_kind <= k;
    in_det_x <= 11'(x);
    in_det_y <= 11'(y);
    in_det_distance <= 14'(d);
    in_frame_ms <= 12'(ms);
    @(posedge clk);
    while (busy) @(posedge clk);
    items++;
  endtask

  task automatic maybe_idle(input bit allow);
    if (allow && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  task automatic drain;
    start <= 1'b0;
    @(posedge clk);
    while (slot_reports.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input int data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= 16'(data);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  stim_row_t rows[] = '{
    '{KIND_EOF, 0, 0, 0, 0, 15},
    '{KIND_DET, -1024, -1024, 16383, 0, -1},
    '{KIND_DET, 1023, 1023, 0, 4095, -1},
    '{KIND_EOF, 0, 0, 0, 4095, 1},
    '{KIND_DET, 988, 988, 5, 0, -1},
    '{KIND_DET, -989, -989, 7, 0, -1},
    '{KIND_EOF, 0, 0, 0, 10, 1},
    '{KIND_EOF, 0, 0, 0, 4095, 1},
    '{KIND_EOF, 0, 0, 0, 0, 15},
    '{KIND_DET, 0, 0, 300, 0, -1},
    '{KIND_DET, 0, 0, 300, 0, -1},
    '{KIND_EOF, -1, -1, 16383, 1, 0}
  };

  initial begin
    int ndet;
    int s;
    int x;
    int y;
    int span;
    bit calm;
    int gates[6];
    int expiries[6];
    gates = '{35, 255, 1, 0, 8, 100};
    expiries = '{500, 65535, 0, 3000, 9000, 200};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (rows[i]) begin
      if (rows[i].kind == KIND_EOF)
        typed_nearest.insert(typed_nearest.size(), rows[i].near);
      send(rows[i].kind, rows[i].x, rows[i].y, rows[i].d, rows[i].ms);
      maybe_idle(1);
    end
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      if (ph == 5) begin
        write_reg(CFG_GATE, $urandom_range(1, 255));
        write_reg(CFG_EXPIRY, $urandom_range(0, 65535));
      end else begin
        write_reg(CFG_GATE, gates[ph]);
        write_reg(CFG_EXPIRY, expiries[ph]);
      end
      while (items < 30 + 30 * (ph + 1)) begin
        calm = items > 170;
        ndet = ($urandom_range(0, 7) == 0) ? $urandom_range(14, 20) : $urandom_range(0, 5);
        for (int k = 0; k < ndet; k++) begin
          s = $urandom_range(0, SLOTS - 1);
          if (tv[s] && $urandom_range(0, 3) != 0) begin
            span = gate_w + 1;
            x = tx[s] + $urandom_range(0, 2 * span) - span;
            y = ty[s] + $urandom_range(0, 2 * span) - span;
            x = x > 1023 ? 1023 : (x < -1024 ? -1024 : x);
            y = y > 1023 ? 1023 : (y < -1024 ? -1024 : y);
          end else begin
            x = $urandom_range(0, 2047) - 1024;
            y = $urandom_range(0, 2047) - 1024;
          end
          send(KIND_DET, x, y, $urandom_range(0, 16383), $urandom_range(0, 4095));
          maybe_idle(!calm);
        end
        if (items == 100) drain();
        send(KIND_EOF, $urandom_range(0, 2047), $urandom_range(0, 2047),
             $urandom_range(0, 16383),
             ($urandom_range(0, 4) == 0) ? 4095 * $urandom_range(0, 1)
                                         : $urandom_range(0, 4095));
        maybe_idle(!calm);
      end
    end
    drain();
    repeat (50) @(posedge clk);
    if (errors == 0 && slot_reports.size() == 0) begin
      $display("[gated_object_track_table_core] OK");
    end else begin
      $display("[gated_object_track_table_core] ERROR");
    end
    $finish;
  end
endmodule
